FILE: hdl/cogr_pkg.sv
`timescale 1ns / 1ps

package cogr_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_OBSTACLES_DEF = 64;
    localparam int MAX_DIM_DEF       = 1024;

    // Signed width of a doubled cell-center coordinate
    localparam int CTR_W  = 26;
    // Signed width of a doubled center-to-obstacle distance
    localparam int DIST_W = 27;
    // Stored obstacle record width
    localparam int OBS_W  = 47;

    // Operation codes carried in the input item
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CELL_SIZE = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
    localparam logic [2:0] REG_GRID_ROWS = 3'd3;
    localparam logic [2:0] REG_GRID_COLS = 3'd4;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] radius;
    } obstacle_t;

    // Status of the scan unit toward the sequencer
    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
        logic match;
    } scan_res_t;

endpackage

FILE: hdl/cogr_ram.sv
`timescale 1ns / 1ps

module cogr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/cogr_scan_unit.sv
`timescale 1ns / 1ps

// Two-stage distance unit: one stored obstacle enters per cycle.
module cogr_scan_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ent_valid,
    input  cogr_pkg::obstacle_t               ent,
    input  cogr_pkg::obstacle_t               probe,
    input  logic signed [cogr_pkg::CTR_W-1:0] center_x,
    input  logic signed [cogr_pkg::CTR_W-1:0] center_y,
    output cogr_pkg::scan_res_t               res
);

    localparam int DW = cogr_pkg::DIST_W;

    logic                   v1_reg;
    logic                   v2_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;
    logic        [15:0]     r2_reg;
    logic                   match1_reg;
    logic        [2*DW-1:0] dx2_reg;
    logic        [2*DW-1:0] dy2_reg;
    logic        [31:0]     rr_reg;
    logic                   match2_reg;

    logic signed [DW-1:0]   dx_next;
    logic signed [DW-1:0]   dy_next;
    logic signed [2*DW-1:0] sq_x;
    logic signed [2*DW-1:0] sq_y;
    logic        [2*DW:0]   dist_sum;

    assign dx_next  = DW'(center_x) - (DW'(ent.x) <<< 1);
    assign dy_next  = DW'(center_y) - (DW'(ent.y) <<< 1);
    assign sq_x     = dx_reg * dx_reg;
    assign sq_y     = dy_reg * dy_reg;
    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ent_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        r2_reg     <= {ent.radius, 1'b0};
        match1_reg <= (ent == probe);
        dx2_reg    <= $unsigned(sq_x);
        dy2_reg    <= $unsigned(sq_y);
        rr_reg     <= r2_reg * r2_reg;
        match2_reg <= match1_reg;
    end

    always_comb
    begin
        res.busy  = v1_reg | v2_reg;
        res.valid = v2_reg;
        res.hit   = v2_reg && (dist_sum <= (2*DW+1)'(rr_reg));
        res.match = v2_reg && match2_reg;
    end

endmodule

FILE: hdl/circle_occupancy_grid_raster.sv
`timescale 1ns / 1ps
// Add and query scan all N stored entries before the result is registered, N the stored
// obstacle count (up to 64 at the default store size); border queries, clear, the unused
// op and an empty store skip the scan. One item is in work at a time: the input is ready
// from the edge that registers the result; the scan at one entry per cycle sets the rate,
// and a held result stalls it.
// Reset (rst_n, async, active low) empties the store and restores the register defaults.
module circle_occupancy_grid_raster #(
    parameter int MAX_OBSTACLES = cogr_pkg::MAX_OBSTACLES_DEF,
    parameter int MAX_DIM       = cogr_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream; tdata from bit 0: op[2], obstacle_x[16], obstacle_y[16],
    // obstacle_radius[15], cell_row[10], cell_col[10], zero pad[3]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    // Result stream; tdata from bit 0: added, store_full, occupied, zero pad[5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW  = $clog2(MAX_OBSTACLES + 1);
    localparam int DMW = ($clog2(MAX_DIM + 1) > 11) ? $clog2(MAX_DIM + 1) : 11;
    localparam int CTW = cogr_pkg::CTR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Configuration registers
    logic        [11:0] cell_size_reg;
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic        [10:0] grid_rows_reg;
    logic        [10:0] grid_cols_reg;

    // Sequencer and item state
    state_t                    state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    cogr_pkg::obstacle_t       obs_reg, obs_next;
    logic [9:0]                row_reg, row_next;
    logic [9:0]                col_reg, col_next;
    logic signed [CTW-1:0]     cx_reg, cx_next;
    logic signed [CTW-1:0]     cy_reg, cy_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             issue_reg, issue_next;
    logic                      rd_valid_reg;
    logic                      hit_reg, hit_next;
    logic                      dup_reg, dup_next;
    logic                      m_valid_reg, m_valid_next;
    logic [2:0]                m_data_reg, m_data_next;

    // Datapath signals
    logic [DMW-1:0]            rows_c, cols_c, row_x, col_x;
    logic                      border;
    logic [22:0]               prod_x, prod_y;
    logic                      rd_en;
    logic                      ram_we;
    logic                      store_is_full;
    logic                      out_free;
    logic [cogr_pkg::OBS_W-1:0] ram_rdata;
    cogr_pkg::obstacle_t       ent;
    cogr_pkg::scan_res_t       scan_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_data_reg};

    // Clamp the grid to the supported dimension and classify the cell
    assign rows_c = (DMW'(grid_rows_reg) > DMW'(MAX_DIM)) ? DMW'(MAX_DIM)
                                                          : DMW'(grid_rows_reg);
    assign cols_c = (DMW'(grid_cols_reg) > DMW'(MAX_DIM)) ? DMW'(MAX_DIM)
                                                          : DMW'(grid_cols_reg);
    assign row_x  = DMW'(row_reg);
    assign col_x  = DMW'(col_reg);
    assign border = (row_x >= rows_c) || (col_x >= cols_c) ||
                    (row_x == '0) || (col_x == '0) ||
                    (row_x == rows_c - DMW'(1)) || (col_x == cols_c - DMW'(1));

    // Doubled cell center: (2*index + 1) * cell_size + 2 * origin
    assign prod_x = {col_reg, 1'b1} * cell_size_reg;
    assign prod_y = {row_reg, 1'b1} * cell_size_reg;

    assign store_is_full = (count_reg == CW'(MAX_OBSTACLES));
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign rd_en         = (state_reg == ST_SCAN) && (issue_reg != count_reg);
    assign ram_we        = (state_reg == ST_DONE) && out_free && (op_reg == cogr_pkg::OP_ADD)
                           && !dup_reg && !store_is_full;
    assign ent           = cogr_pkg::obstacle_t'(ram_rdata);

    cogr_ram #(
        .WIDTH (cogr_pkg::OBS_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (obs_reg),
        .re    (rd_en),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    cogr_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent_valid (rd_valid_reg),
        .ent       (ent),
        .probe     (obs_reg),
        .center_x  (cx_reg),
        .center_y  (cy_reg),
        .res       (scan_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        obs_next     = obs_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        hit_next     = hit_reg;
        dup_next     = dup_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the item on its transfer
                if (s_axis_tvalid)
                begin
                    op_next        = s_axis_tdata[1:0];
                    obs_next.x     = s_axis_tdata[17:2];
                    obs_next.y     = s_axis_tdata[33:18];
                    obs_next.radius = s_axis_tdata[48:34];
                    row_next       = s_axis_tdata[58:49];
                    col_next       = s_axis_tdata[68:59];
                    state_next     = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cx_next    = $signed({3'b0, prod_x}) + (CTW'(origin_x_reg) <<< 1);
                cy_next    = $signed({3'b0, prod_y}) + (CTW'(origin_y_reg) <<< 1);
                hit_next   = border;
                dup_next   = 1'b0;
                issue_next = '0;
                state_next = ST_DONE;
                // Scan only when the answer depends on the stored obstacles
                if ((op_reg == cogr_pkg::OP_ADD) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                if ((op_reg == cogr_pkg::OP_QUERY) && !border && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                hit_next = hit_reg | scan_res.hit;
                dup_next = dup_reg | scan_res.match;
                // Finish once every entry is issued and the unit has drained
                if ((issue_reg == count_reg) && !rd_valid_reg && !scan_res.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    case (op_reg)
                        cogr_pkg::OP_ADD:
                        begin
                            m_data_next[0] = !dup_reg && !store_is_full;
                            m_data_next[1] = !dup_reg && store_is_full;
                            if (ram_we)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cogr_pkg::OP_QUERY:
                        begin
                            m_data_next[2] = hit_reg;
                        end
                        cogr_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            m_data_next = '0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            obs_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            dup_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            obs_reg      <= obs_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_en;
            hit_reg      <= hit_next;
            dup_reg      <= dup_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
        end
    end

    // Configuration registers, written by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= 12'd50;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            grid_rows_reg <= 11'd1;
            grid_cols_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                cogr_pkg::REG_CELL_SIZE: cell_size_reg <= cfg_wdata[11:0];
                cogr_pkg::REG_ORIGIN_X:  origin_x_reg  <= cfg_wdata;
                cogr_pkg::REG_ORIGIN_Y:  origin_y_reg  <= cfg_wdata;
                cogr_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata[10:0];
                cogr_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata[10:0];
                default:
                begin
                end
            endcase
        end
    end

    // The obstacle count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_OBSTACLES))
        else $error("obstacle count beyond store size");

    // A store write advances the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("store write without count advance");

    // Reads stay below the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg))
        else $error("read beyond filled entries");

    // Scan results arrive only while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.valid |-> (state_reg == ST_SCAN))
        else $error("scan result outside scan");

    // At most one result flag is set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> $onehot0(m_data_reg))
        else $error("conflicting result flags");

endmodule
